// ----- rtl/core/sfd_pkg.sv -----
package sfd_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]  START_BYTE = 8'hFF;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // frame byte positions (byte 0 is the start byte)
  localparam logic [4:0] POS_FIRST    = 5'd1;
  localparam logic [4:0] POS_LAST_CRC = 5'd19;
  localparam logic [4:0] POS_CRC_LO   = 5'd20;
  localparam logic [4:0] POS_CRC_HI   = 5'd21;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_CRC_LO,
    KIND_CRC_HI
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  pos;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic               status;
    logic        [15:0] speed_left;
    logic        [15:0] speed_right;
    logic signed [31:0] odometry_left;
    logic signed [31:0] odometry_right;
    logic        [7:0]  battery_voltage;
    logic        [7:0]  motor_current;
  } result_t;

  // CRC-16/Modbus, one byte, eight bit steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/sfd_front.sv -----
module sfd_front import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  logic       in_frame;
  logic       in_frame_next;
  logic [4:0] byte_index;
  logic [4:0] byte_index_next;
  logic       accept;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    in_frame_next   = in_frame;
    byte_index_next = byte_index;
    push            = 1'b0;
    push_item.kind  = KIND_DATA;
    push_item.pos   = byte_index;
    push_item.data  = s_tdata;
    if (accept) begin
      if (!in_frame) begin
        // hunting: only a start byte opens a frame
        if (s_tdata == START_BYTE) begin
          push            = 1'b1;
          push_item.kind  = KIND_START;
          in_frame_next   = 1'b1;
          byte_index_next = POS_FIRST;
        end
      end else begin
        push = 1'b1;
        if (byte_index <= POS_LAST_CRC) begin
          push_item.kind  = KIND_DATA;
          byte_index_next = byte_index + 5'd1;
        end else if (byte_index == POS_CRC_LO) begin
          push_item.kind  = KIND_CRC_LO;
          byte_index_next = POS_CRC_HI;
        end else begin
          push_item.kind  = KIND_CRC_HI;
          in_frame_next   = 1'b0;
          byte_index_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_index <= '0;
    end else begin
      in_frame   <= in_frame_next;
      byte_index <= byte_index_next;
    end
  end

endmodule

// ----- rtl/core/sfd_queue.sv -----
module sfd_queue import sfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  empty,
  output logic  full,
  output item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/sfd_back.sv -----
module sfd_back import sfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t result
);

  localparam logic [4:0] POS_SPD_L_LO = 5'd1;
  localparam logic [4:0] POS_SPD_L_HI = 5'd2;
  localparam logic [4:0] POS_VOLT     = 5'd3;
  localparam logic [4:0] POS_ODO_L0   = 5'd6;
  localparam logic [4:0] POS_ODO_L1   = 5'd7;
  localparam logic [4:0] POS_ODO_L2   = 5'd8;
  localparam logic [4:0] POS_ODO_L3   = 5'd9;
  localparam logic [4:0] POS_SPD_R_LO = 5'd10;
  localparam logic [4:0] POS_SPD_R_HI = 5'd11;
  localparam logic [4:0] POS_ODO_R0   = 5'd14;
  localparam logic [4:0] POS_ODO_R1   = 5'd15;
  localparam logic [4:0] POS_ODO_R2   = 5'd16;
  localparam logic [4:0] POS_ODO_R3   = 5'd17;
  localparam logic [4:0] POS_CURR     = 5'd18;

  logic [15:0] running_crc;
  logic [7:0]  crc_low_seen;
  logic [15:0] left_speed_hold;
  logic [15:0] right_speed_hold;
  logic [31:0] left_odometry_hold;
  logic [31:0] right_odometry_hold;
  logic [7:0]  voltage_hold;
  logic [7:0]  current_hold;
  logic        out_free;
  logic        crc_ok;

  // only the closing byte needs the output register
  assign out_free = !m_tvalid || m_tready;
  assign pop      = item_valid && ((item.kind != KIND_CRC_HI) || out_free);
  assign crc_ok   = (crc_low_seen == running_crc[7:0]) && (item.data == running_crc[15:8]);

  always_ff @(posedge clk) begin
    if (pop) begin
      case (item.kind)
        KIND_START: begin
          running_crc <= CRC_INIT;
        end
        KIND_DATA: begin
          running_crc <= crc_feed(running_crc, item.data);
          case (item.pos)
            POS_SPD_L_LO: left_speed_hold[7:0]       <= item.data;
            POS_SPD_L_HI: left_speed_hold[15:8]      <= item.data;
            POS_VOLT:     voltage_hold               <= item.data;
            POS_ODO_L0:   left_odometry_hold[7:0]    <= item.data;
            POS_ODO_L1:   left_odometry_hold[15:8]   <= item.data;
            POS_ODO_L2:   left_odometry_hold[23:16]  <= item.data;
            POS_ODO_L3:   left_odometry_hold[31:24]  <= item.data;
            POS_SPD_R_LO: right_speed_hold[7:0]      <= item.data;
            POS_SPD_R_HI: right_speed_hold[15:8]     <= item.data;
            POS_ODO_R0:   right_odometry_hold[7:0]   <= item.data;
            POS_ODO_R1:   right_odometry_hold[15:8]  <= item.data;
            POS_ODO_R2:   right_odometry_hold[23:16] <= item.data;
            POS_ODO_R3:   right_odometry_hold[31:24] <= item.data;
            POS_CURR:     current_hold               <= item.data;
            default: ;
          endcase
        end
        KIND_CRC_LO: begin
          crc_low_seen <= item.data;
        end
        KIND_CRC_HI: begin
          result.status          <= !crc_ok;
          result.speed_left      <= crc_ok ? left_speed_hold : '0;
          result.speed_right     <= crc_ok ? right_speed_hold : '0;
          result.odometry_left   <= crc_ok ? left_odometry_hold : '0;
          result.odometry_right  <= crc_ok ? right_odometry_hold : '0;
          result.battery_voltage <= crc_ok ? voltage_hold : '0;
          result.motor_current   <= crc_ok ? current_hold : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && (item.kind == KIND_CRC_HI)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/status_frame_deframer_crc16.sv -----
// Channel   Dir  Fields (tdata/tuser, low bit up)             Transfer
// s_*       in   tdata: rx_byte[7:0]                           s_tvalid & s_tready
// m_*       out  tdata: speed_left, speed_right,               m_tvalid & m_tready
//                odometry_left, odometry_right,
//                battery_voltage, motor_current; tuser: frame_status
//
// One byte per cycle, sustained while the queue has room. The front tracks
// frame position per byte; the back runs a byte's eight CRC bit steps at once.
// The closing CRC byte reaches m_tvalid via the queue and the result register.
// Reset (rst, sync, active high) returns to hunting and empties the queue.
// A stalled m_tready only holds the closing byte; data bytes keep flowing until
// the queue fills, then s_tready drops.
module status_frame_deframer_crc16 import sfd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // 2 and up
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] speed_left, [31:16] speed_right, [63:32] odometry_left,
  // [95:64] odometry_right, [103:96] battery_voltage, [111:104] motor_current
  output logic [111:0] m_tdata,
  output logic [0:0]   m_tuser    // [0] frame_status: 0 ok, 1 CRC mismatch
);

  logic    q_push;
  item_t   q_push_item;
  logic    q_pop;
  logic    q_empty;
  logic    q_full;
  item_t   q_head;
  result_t result;

  // front: hunts for start byte, tags each frame byte with its role
  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (q_full),
    .push       (q_push),
    .push_item  (q_push_item)
  );

  // decouples byte intake from a stalled result
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .full      (q_full),
    .head      (q_head)
  );

  // back: CRC, field capture, result register
  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!q_empty),
    .item       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  assign m_tdata = {result.motor_current, result.battery_voltage,
                    result.odometry_right, result.odometry_left,
                    result.speed_right, result.speed_left};
  assign m_tuser = result.status;

  // a new result only follows the closing CRC byte leaving the queue
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_pop && (q_head.kind == KIND_CRC_HI)))
    else $error("result without closing CRC byte");

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("push into full queue");

  // nothing popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("pop from empty queue");

  // reset clears the output side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

endmodule

// ----- bench/status_frame_deframer_crc16_tb.sv -----
module status_frame_deframer_crc16_tb import sfd_pkg::*; ();

  // status values carried on m_tuser
  localparam logic FRAME_OK      = 1'b0;
  localparam logic FRAME_CRC_BAD = 1'b1;

  // receiver hold-off long enough to fill the byte queue and back up s_tready
  localparam int LONG_HOLD = 300;

  // directed table row kinds: checksum rows are filled in from the bytes before them
  typedef enum logic [1:0] {
    ROW_DATA,
    ROW_START,
    ROW_CRC_LO,
    ROW_CRC_HI
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
  } row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_t;

  // good frame built from field extremes, result read straight off the bytes
  localparam result_t DIRECTED_WANT = '{FRAME_OK, 16'hFFFF, 16'h0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 8'h00, 8'hFF};

  // two noise bytes while hunting, then one frame; 0xFF data bytes must not restart it
  row_t dir_rows [0:23] = '{
    '{ROW_DATA,   8'h00},  // ignored while hunting
    '{ROW_DATA,   8'hFE},  // ignored while hunting
    '{ROW_START,  8'hFF},
    '{ROW_DATA,   8'hFF},  // 1,2: speed_left
    '{ROW_DATA,   8'hFF},
    '{ROW_DATA,   8'h00},  // 3: voltage
    '{ROW_DATA,   8'h5A},  // 4,5: checksum only
    '{ROW_DATA,   8'hA5},
    '{ROW_DATA,   8'h00},  // 6..9: odometry_left, most negative
    '{ROW_DATA,   8'h00},
    '{ROW_DATA,   8'h00},
    '{ROW_DATA,   8'h80},
    '{ROW_DATA,   8'h00},  // 10,11: speed_right
    '{ROW_DATA,   8'h00},
    '{ROW_DATA,   8'hFF},  // 12,13: checksum only
    '{ROW_DATA,   8'h01},
    '{ROW_DATA,   8'hFF},  // 14..17: odometry_right, most positive
    '{ROW_DATA,   8'hFF},
    '{ROW_DATA,   8'hFF},
    '{ROW_DATA,   8'h7F},
    '{ROW_DATA,   8'hFF},  // 18: current
    '{ROW_DATA,   8'h00},  // 19: checksum only
    '{ROW_CRC_LO, 8'h00},
    '{ROW_CRC_HI, 8'h00}
  };

  logic           clk = 1'b0;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [7:0]     s_tdata;
  logic           m_tvalid;
  logic           m_tready;
  logic [111:0]   m_tdata;
  logic [0:0]     m_tuser;

  // expectation typed into the table, travels with the byte that closes the frame
  logic           tab_typed;
  result_t        tab_want;

  // deframer state as the bench tracks it
  logic           fr_active;
  logic [4:0]     fr_pos;
  logic [15:0]    fr_crc;
  logic [7:0]     fr_crc_lo;
  logic [15:0]    hold_speed_l;
  logic [15:0]    hold_speed_r;
  logic [31:0]    hold_odo_l;
  logic [31:0]    hold_odo_r;
  logic [7:0]     hold_volt;
  logic [7:0]     hold_curr;

  result_t        frame_results_q [$];
  int             bytes_taken;
  int             results_seen;
  int             mismatch_cnt;
  int             items_sent;
  int             burst_left;

  always #1 clk = ~clk;

  status_frame_deframer_crc16 i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // CRC-16/Modbus, one input bit per step, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // data bytes lean on 0x00 and 0xFF so every field sees its extremes
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // one accepted byte through the deframer; fires on the closing checksum byte
  task automatic deframe_byte(input logic [7:0] b, output bit fired, output result_t res);
    fired = 1'b0;
    res   = '0;
    if (!fr_active) begin
      if (b == START_BYTE) begin
        fr_active = 1'b1;
        fr_pos    = POS_FIRST;
        fr_crc    = CRC_INIT;
      end
    end else if (fr_pos >= POS_FIRST && fr_pos <= POS_LAST_CRC) begin
      fr_crc = crc16_byte(fr_crc, b);
      case (fr_pos)
        5'd1:                    hold_speed_l[7:0]  = b;
        5'd2:                    hold_speed_l[15:8] = b;
        5'd3:                    hold_volt          = b;
        5'd6, 5'd7, 5'd8, 5'd9:  hold_odo_l[8 * (int'(fr_pos) - 6) +: 8] = b;
        5'd10:                   hold_speed_r[7:0]  = b;
        5'd11:                   hold_speed_r[15:8] = b;
        5'd14, 5'd15, 5'd16, 5'd17: hold_odo_r[8 * (int'(fr_pos) - 14) +: 8] = b;
        5'd18:                   hold_curr          = b;
        default: ;               // checksum only
      endcase
      fr_pos = fr_pos + 5'd1;
    end else if (fr_pos == POS_CRC_LO) begin
      fr_crc_lo = b;
      fr_pos    = POS_CRC_HI;
    end else if (fr_pos == POS_CRC_HI) begin
      fired     = 1'b1;
      fr_active = 1'b0;
      fr_pos    = '0;
      if (fr_crc_lo == fr_crc[7:0] && b == fr_crc[15:8]) begin
        res.status          = FRAME_OK;
        res.speed_left      = hold_speed_l;
        res.speed_right     = hold_speed_r;
        res.odometry_left   = hold_odo_l;
        res.odometry_right  = hold_odo_r;
        res.battery_voltage = hold_volt;
        res.motor_current   = hold_curr;
      end else begin
        res.status = FRAME_CRC_BAD;  // all data fields stay zero
      end
    end else begin
      fr_active = 1'b0;
      fr_pos    = '0;
    end
  endtask

  // Offer one byte, hold it until the transfer, then maybe end the burst with a gap.
  // Called at a falling edge, returns at a falling edge.
  task automatic put_byte(input logic [7:0] b, input bit typed, input result_t want);
    int taken_before;
    taken_before = bytes_taken;
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    tab_typed <= typed;
    tab_want  <= want;
    do @(negedge clk); while (bytes_taken == taken_before);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= 8'($urandom);
      tab_typed <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Scoreboard: predict on every input transfer, check every output transfer.
  always @(posedge clk) begin : scoreboard
    bit      fired;
    result_t pred;
    result_t got;
    result_t want;
    if (rst) begin
      fr_active    = 1'b0;
      fr_pos       = '0;
      fr_crc       = CRC_INIT;
      fr_crc_lo    = '0;
      hold_speed_l = '0;
      hold_speed_r = '0;
      hold_odo_l   = '0;
      hold_odo_r   = '0;
      hold_volt    = '0;
      hold_curr    = '0;
      frame_results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata, fired, pred);
        if (fired) frame_results_q.push_back(tab_typed ? tab_want : pred);
        bytes_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.status          = m_tuser[0];
        got.speed_left      = m_tdata[15:0];
        got.speed_right     = m_tdata[31:16];
        got.odometry_left   = m_tdata[63:32];
        got.odometry_right  = m_tdata[95:64];
        got.battery_voltage = m_tdata[103:96];
        got.motor_current   = m_tdata[111:104];
        if (frame_results_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("result %0d: no frame pending, got status %0b data %h",
                     results_seen, got.status, m_tdata);
          mismatch_cnt++;
        end else begin
          want = frame_results_q.pop_front();
          if (got.status !== want.status || got.speed_left !== want.speed_left ||
              got.speed_right !== want.speed_right ||
              got.odometry_left !== want.odometry_left ||
              got.odometry_right !== want.odometry_right ||
              got.battery_voltage !== want.battery_voltage ||
              got.motor_current !== want.motor_current) begin
            if (mismatch_cnt < 10) begin
              $display("result %0d expected: st %0b sl %h sr %h ol %h or %h v %h c %h",
                       results_seen, want.status, want.speed_left, want.speed_right,
                       want.odometry_left, want.odometry_right, want.battery_voltage,
                       want.motor_current);
              $display("result %0d actual:   st %0b sl %h sr %h ol %h or %h v %h c %h",
                       results_seen, got.status, got.speed_left, got.speed_right,
                       got.odometry_left, got.odometry_right, got.battery_voltage,
                       got.motor_current);
            end
            mismatch_cnt++;
          end
        end
        results_seen++;
      end
    end
  end

  // Receiver: switches between open, choppy and sparse stretches. Once, after a
  // few frames, it holds off long enough for the block to fill and stall s_tready.
  initial begin : sink
    rx_mode_t mode;
    int       mode_left;
    bit       held;
    m_tready  = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 15) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= 1'b1;
        endcase
      end
    end
  end

  // Sender: directed table first, then random frames, noise and cut-off frames.
  initial begin : source
    row_t        r;
    logic [7:0]  b;
    logic [15:0] tab_crc;
    logic [15:0] crc;
    int          pick;
    bit          paused;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    tab_typed  = 1'b0;
    tab_want   = '0;
    bytes_taken  = 0;
    results_seen = 0;
    mismatch_cnt = 0;
    items_sent   = 0;
    burst_left   = $urandom_range(1, 24);
    paused       = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    tab_crc = CRC_INIT;
    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      case (r.kind)
        ROW_START: begin
          b       = START_BYTE;
          tab_crc = CRC_INIT;
        end
        ROW_DATA: begin
          b       = r.value;
          tab_crc = crc16_byte(tab_crc, b);
        end
        ROW_CRC_LO: b = tab_crc[7:0];
        default:    b = tab_crc[15:8];
      endcase
      put_byte(b, r.kind == ROW_CRC_HI, DIRECTED_WANT);
    end

    while (items_sent < 1250) begin
      // once midway, let the block drain completely before going on
      if (!paused && items_sent >= 700) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        // whole frame; the top slice gets one checksum bit flipped
        put_byte(START_BYTE, 1'b0, '0);
        crc = CRC_INIT;
        for (int i = 1; i <= 19; i++) begin
          b   = rand_byte();
          crc = crc16_byte(crc, b);
          put_byte(b, 1'b0, '0);
        end
        if (pick >= 70) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        put_byte(crc[7:0], 1'b0, '0);
        put_byte(crc[15:8], 1'b0, '0);
      end else if (pick < 91) begin
        // line noise; a 0xFF here opens a frame that later bytes fill
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'b0, '0);
      end else begin
        // cut-off frame: the next start byte lands inside it as data
        put_byte(START_BYTE, 1'b0, '0);
        repeat ($urandom_range(1, 20)) put_byte(rand_byte(), 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk);
    // then idle on to catch any stray result
    repeat (10) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sfd_pkg.sv
rtl/core/sfd_front.sv
rtl/core/sfd_queue.sv
rtl/core/sfd_back.sv
rtl/core/status_frame_deframer_crc16.sv
bench/status_frame_deframer_crc16_tb.sv
